// File: src/dlt_pkg.sv
// Shared types and constants of the detection lock tracker.
package dlt_pkg;

   typedef enum logic [1:0] {
      ST_NONE     = 2'd0,
      ST_DETECTED = 2'd1,
      ST_LOCKED   = 2'd2,
      ST_LOST     = 2'd3
   } track_type;

   typedef enum logic [1:0] {
      OUT_IGNORED   = 2'd0,
      OUT_COOLDOWN  = 2'd1,
      OUT_PROCESSED = 2'd2,
      OUT_UNUSED    = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      KIND_FRAME = 2'd0,
      KIND_START = 2'd1,
      KIND_STOP  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_OFF      = 2'd0,
      MODE_MONITOR  = 2'd1,
      MODE_AUTO     = 2'd2,
      MODE_ASSISTED = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'd0,
      S_SCAN  = 3'd1,
      S_MULQ  = 3'd2,
      S_MULS  = 3'd3,
      S_APPLY = 3'd4
   } fsm_type;

   localparam logic [3:0] CSR_RUN_MODE   = 4'd0;
   localparam logic [3:0] CSR_COOLDOWN   = 4'd1;
   localparam logic [3:0] CSR_LOCK_LIMIT = 4'd2;
   localparam logic [3:0] CSR_STRICT     = 4'd3;

   localparam logic [31:0] LOST_TIMEOUT_MS  = 32'd1000;
   localparam logic [31:0] AUTO_MIN_LOCK_MS = 32'd1000;
   localparam logic [15:0] LOCK_MIN_HITS    = 16'd3;
   localparam logic [15:0] STRICT_MIN_HITS  = 16'd5;
   // 0.8 in Q0.16 is met when 5 * confidence >= 4 * 65536.
   localparam logic [18:0] CONF_THRESH_X5   = 19'd262144;

endpackage

// File: src/dlt_sermul.sv
// Shift-and-add multiplier that retires one multiplier bit per cycle.
module dlt_sermul #(
   parameter int AW = 37,
   parameter int BW = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic             done,
   output logic [AW+BW-1:0] product
);
   localparam int PW = AW + BW;
   localparam int CW = $clog2(BW + 1);

   logic [PW-1:0] a_ff, a_in, acc_ff, acc_in;
   logic [BW-1:0] b_ff, b_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = {{BW{1'b0}}, a};
         b_in   = b;
         acc_in = '0;
         cnt_in = CW'(BW);
      end else if (cnt_ff != '0) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in    = a_ff << 1;
         b_in    = b_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: src/dlt_hist.sv
// Confidence history ring with a one-entry-per-cycle count, sum and square-sum scan.
module dlt_hist #(
   parameter int DEPTH = 5,
   parameter int NW    = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             wr_en,
   input  logic [15:0]      wr_data,
   input  logic             scan_start,
   output logic             scan_done,
   output logic [NW-1:0]    cnt,
   output logic [NW+15:0]   sum,
   output logic [NW+31:0]   sumsq
);
   localparam int IW = $clog2(DEPTH);

   logic [15:0]      hist_ff [DEPTH];
   logic [IW-1:0]    slot_ff, idx_ff;
   logic             busy_ff, done_ff;
   logic [NW-1:0]    n_ff;
   logic [NW+15:0]   s_ff;
   logic [NW+31:0]   q_ff;
   logic [15:0]      v;
   logic [31:0]      vsq;

   assign v   = hist_ff[idx_ff];
   assign vsq = v * v;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         slot_ff <= '0;
      end else if (wr_en) begin
         hist_ff[slot_ff] <= wr_data;
         slot_ff <= (slot_ff == IW'(DEPTH - 1)) ? '0 : slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (scan_start) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (busy_ff) begin
            idx_ff <= idx_ff + 1'b1;
            if (idx_ff == IW'(DEPTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (scan_start) begin
         n_ff <= '0;
         s_ff <= '0;
         q_ff <= '0;
      end else if (busy_ff && v != '0) begin
         n_ff <= n_ff + 1'b1;
         s_ff <= s_ff + (NW+16)'(v);
         q_ff <= q_ff + (NW+32)'(vsq);
      end
   end

   assign scan_done = done_ff;
   assign cnt       = n_ff;
   assign sum       = s_ff;
   assign sumsq     = q_ff;

endmodule

// File: src/detection_lock_tracker.sv
// Detection lock tracker top level: control sequencer, state registers and stream ports.
// One beat in gives one beat out. Control events, ignored frames, cooldown skips and
// frames without a hit pass from the scan state straight to the apply state. A processed
// hit runs the stability test: a scan of the history, one entry per cycle, then two
// products on a shared bit-serial multiplier. The result moves into the output register
// only once the previous result has been taken, and the next beat is accepted in the
// cycle after that.
module detection_lock_tracker #(
   parameter int HISTORY_DEPTH = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // now_ms[31:0], hit[32], confidence[48:33], supply_left[64:49]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [151:0] rsp_tdata,  // track_status[1:0], lock_event[2], lost_event[3], stable[4],
                                    // hit_streak[20:5], lock_span_ms[52:21], frames_seen[84:53],
                                    // hits_seen[116:85], locks_seen[148:117]
   output logic [1:0]  rsp_tuser,   // outcome[1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [15:0] csr_data
);
   import dlt_pkg::*;

   localparam int NW = $clog2(HISTORY_DEPTH + 1);
   localparam int SW = NW + 16;
   localparam int QW = NW + 32;
   localparam int PW = QW + SW;

   // configuration
   logic [1:0]  mode_ff;
   logic [15:0] cooldown_ff, limit_ff;
   logic        strict_ff;

   // latched request
   logic [1:0]  kind_ff;
   logic [31:0] now_ff;
   logic        hit_ff;
   logic [15:0] conf_ff, supply_ff;

   // tracker state
   logic        running_ff, running_in;
   track_type   status_ff, status_in;
   logic [15:0] streak_ff, streak_in, held_ff, held_in;
   logic [31:0] last_ff, last_in, lstart_ff, lstart_in, event_ff, event_in;
   logic [31:0] span_ff, span_in, frames_ff, frames_in, hits_ff, hits_in;
   logic [31:0] locks_ff, locks_in;
   logic        stable_ff, stable_in;

   fsm_type     state_ff, state_in;
   logic        stab_ff, stab_in;
   logic [PW+2:0] lhs_ff, lhs_in;

   logic        rsp_valid_ff;
   logic [151:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   logic        accept, commit, need_test, cooling;
   logic        hist_clear, hist_wr, scan_start, scan_done;
   logic [NW-1:0] h_cnt;
   logic [SW-1:0] h_sum;
   logic [QW-1:0] h_sq;
   logic        mul_start, mul_done;
   logic [QW-1:0] mul_a;
   logic [SW-1:0] mul_b;
   logic [PW-1:0] mul_p;
   outcome_type outcome_v;
   logic        lk, ls, lock_ok;
   logic [18:0] conf_x5;

   assign accept    = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign cooling   = (last_ff != '0) && ((now_ff - last_ff) < {16'd0, cooldown_ff});
   assign need_test = (kind_ff == KIND_FRAME) && running_ff && !cooling && hit_ff;
   assign commit    = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_tready);

   dlt_hist #(.DEPTH(HISTORY_DEPTH), .NW(NW)) u_hist (
      .clock(clock), .reset(reset), .clear(hist_clear), .wr_en(hist_wr),
      .wr_data(conf_ff), .scan_start(scan_start), .scan_done(scan_done),
      .cnt(h_cnt), .sum(h_sum), .sumsq(h_sq)
   );

   dlt_sermul #(.AW(QW), .BW(SW)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .product(mul_p)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_SCAN;
         S_SCAN: begin
            if (!need_test) state_in = S_APPLY;
            else if (scan_done) state_in = S_MULQ;
         end
         S_MULQ:  if (mul_done) state_in = S_MULS;
         S_MULS:  if (mul_done) state_in = S_APPLY;
         S_APPLY: if (commit) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      scan_start = 1'b0;
      mul_start  = 1'b0;
      mul_a      = h_sq;
      mul_b      = SW'(h_cnt);
      lhs_in     = lhs_ff;
      stab_in    = stab_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            scan_start = accept;
         end
         S_SCAN: begin
            mul_start = need_test && scan_done;
         end
         S_MULQ: begin
            mul_a = QW'(h_sum);
            mul_b = h_sum;
            if (mul_done) begin
               mul_start = 1'b1;
               lhs_in    = ({3'b0, mul_p} << 2) + {3'b0, mul_p};
            end
         end
         S_MULS: begin
            if (mul_done) begin
               stab_in = (h_cnt != '0) &&
                         (lhs_ff < (({3'b0, mul_p} << 2) + ({3'b0, mul_p} << 1)));
            end
         end
         S_APPLY: ;
         default: ;
      endcase
   end

   // tracker update, taken at commit
   always_comb begin
      running_in = running_ff;
      status_in  = status_ff;
      streak_in  = streak_ff;
      held_in    = held_ff;
      last_in    = last_ff;
      lstart_in  = lstart_ff;
      event_in   = event_ff;
      span_in    = span_ff;
      frames_in  = frames_ff;
      hits_in    = hits_ff;
      locks_in   = locks_ff;
      stable_in  = stable_ff;
      hist_clear = 1'b0;
      hist_wr    = 1'b0;
      outcome_v  = OUT_IGNORED;
      lk         = 1'b0;
      ls         = 1'b0;
      lock_ok    = 1'b0;
      conf_x5    = 19'd0;
      if (kind_ff == KIND_START) begin
         running_in = (mode_ff != MODE_OFF);
         if (mode_ff != MODE_OFF) begin
            status_in  = ST_NONE;
            streak_in  = '0;
            last_in    = '0;
            lstart_in  = '0;
            hist_clear = commit;
         end
      end else if (kind_ff == KIND_STOP) begin
         running_in = 1'b0;
         status_in  = ST_NONE;
      end else if (kind_ff == KIND_NONE || !running_ff) begin
         outcome_v = OUT_IGNORED;
      end else if (cooling) begin
         outcome_v = OUT_COOLDOWN;
      end else begin
         outcome_v = OUT_PROCESSED;
         frames_in = frames_ff + 1'b1;
         if (hit_ff) begin
            hits_in   = hits_ff + 1'b1;
            if (streak_ff != 16'hFFFF) streak_in = streak_ff + 1'b1;
            held_in   = conf_ff;
            event_in  = now_ff;
            stable_in = stab_ff;
            if (status_ff == ST_NONE || status_ff == ST_LOST) begin
               status_in = ST_DETECTED;
            end else if (status_ff == ST_DETECTED && streak_in >= LOCK_MIN_HITS && stab_ff) begin
               status_in = ST_LOCKED;
               lstart_in = now_ff;
               locks_in  = locks_ff + 1'b1;
            end
            if (status_in == ST_LOCKED) span_in = now_ff - lstart_in;
         end else begin
            streak_in = '0;
            if (status_ff == ST_DETECTED || status_ff == ST_LOCKED) begin
               status_in = ST_LOST;
               event_in  = now_ff;
            end else if (status_ff == ST_LOST && (now_ff - event_ff) > LOST_TIMEOUT_MS) begin
               status_in = ST_NONE;
               span_in   = '0;
            end
         end
         hist_wr = commit;
         last_in = now_ff;
         conf_x5 = ({3'b0, held_in} << 2) + {3'b0, held_in};
         lock_ok = !(strict_ff && (conf_x5 < CONF_THRESH_X5 || streak_in < STRICT_MIN_HITS))
                   && !(mode_ff == MODE_AUTO && span_in < AUTO_MIN_LOCK_MS)
                   && (supply_ff != '0);
         if (mode_ff != MODE_MONITOR) begin
            if (status_in == ST_LOCKED) begin
               if (!lock_ok) begin
                  status_in = ST_DETECTED;
               end else begin
                  lk = 1'b1;
                  if (span_in > {16'd0, limit_ff}) status_in = ST_DETECTED;
               end
            end else if (status_in == ST_LOST) begin
               ls = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_MONITOR;
         cooldown_ff  <= 16'd500;
         limit_ff     <= 16'd2000;
         strict_ff    <= 1'b1;
         running_ff   <= 1'b0;
         status_ff    <= ST_NONE;
         streak_ff    <= '0;
         held_ff      <= '0;
         last_ff      <= '0;
         lstart_ff    <= '0;
         event_ff     <= '0;
         span_ff      <= '0;
         frames_ff    <= '0;
         hits_ff      <= '0;
         locks_ff     <= '0;
         stable_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_RUN_MODE:   mode_ff     <= csr_data[1:0];
               CSR_COOLDOWN:   cooldown_ff <= csr_data;
               CSR_LOCK_LIMIT: limit_ff    <= csr_data;
               CSR_STRICT:     strict_ff   <= csr_data[0];
               default: ;
            endcase
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            running_ff   <= running_in;
            status_ff    <= status_in;
            streak_ff    <= streak_in;
            held_ff      <= held_in;
            last_ff      <= last_in;
            lstart_ff    <= lstart_in;
            event_ff     <= event_in;
            span_ff      <= span_in;
            frames_ff    <= frames_in;
            hits_ff      <= hits_in;
            locks_ff     <= locks_in;
            stable_ff    <= stable_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         kind_ff   <= req_tuser;
         now_ff    <= req_tdata[31:0];
         hit_ff    <= req_tdata[32];
         conf_ff   <= req_tdata[48:33];
         supply_ff <= req_tdata[64:49];
      end
      lhs_ff <= lhs_in;
      stab_ff <= stab_in;
      if (commit) begin
         rsp_user_ff <= outcome_v;
         rsp_data_ff <= {3'b0, locks_in, hits_in, frames_in, span_in, streak_in,
                         stable_in, ls, lk, status_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A lost track always follows a frame without a hit.
   a_lost_no_streak: assert property (@(posedge clock) disable iff (reset)
      status_ff == ST_LOST |-> streak_ff == '0)
      else $error("lost status with nonzero streak");

   // A lock notification leaves the track locked or detected.
   a_lock_event_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |->
         (rsp_tdata[1:0] == ST_LOCKED || rsp_tdata[1:0] == ST_DETECTED))
      else $error("lock event with bad status");

   // Lock and lost notifications are never issued together, and only on processed frames.
   a_event_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2] || rsp_tdata[3]) |->
         !(rsp_tdata[2] && rsp_tdata[3]) && rsp_tuser == OUT_PROCESSED)
      else $error("notification on unprocessed frame");

   // The multiplier only finishes inside the stability test.
   a_mul_window: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_MULQ || state_ff == S_MULS))
      else $error("multiplier done outside test");

endmodule

// File: dv/tb.sv
// Self-checking testbench of the detection lock tracker: directed and random beats.
`timescale 1ns / 1ps
module tb;
   import dlt_pkg::*;

   typedef struct packed {
      outcome_type outcome;
      track_type   status;
      logic        lock_ev;
      logic        lost_ev;
      logic        stable;
      logic [15:0] streak;
      logic [31:0] lock_time;
      logic [31:0] frames;
      logic [31:0] hits;
      logic [31:0] locks;
   } verdict_type;

   // Scoreboard: a lock tracker of its own plus the queue of verdicts it expects.
   class tracker_board_type;
      mode_type    mode;
      logic [15:0] cooldown, lock_limit;
      logic        strict;
      logic        running;
      track_type   status;
      logic [15:0] streak;
      logic [31:0] last_t, lock_t0, event_t, span;
      logic [15:0] held_conf;
      logic        stable;
      logic [15:0] hist [5];
      int          slot;
      logic [31:0] frames, hits, locks;
      verdict_type pending[$];
      int          errors, matched;

      function void clear();
         mode = MODE_MONITOR; cooldown = 16'd500; lock_limit = 16'd2000; strict = 1'b1;
         running = 1'b0; status = ST_NONE; streak = '0; last_t = '0; lock_t0 = '0;
         event_t = '0; span = '0; held_conf = '0; stable = 1'b0; slot = 0;
         frames = '0; hits = '0; locks = '0;
         foreach (hist[i]) hist[i] = '0;
         errors = 0; matched = 0;
      endfunction

      function void write_reg(logic [3:0] idx, logic [15:0] val);
         case (idx)
            CSR_RUN_MODE:   mode = mode_type'(val[1:0]);
            CSR_COOLDOWN:   cooldown = val;
            CSR_LOCK_LIMIT: lock_limit = val;
            CSR_STRICT:     strict = val[0];
            default: ;
         endcase
      endfunction

      function logic history_stable();
         logic [63:0] n, s, q;
         n = '0; s = '0; q = '0;
         foreach (hist[i]) if (hist[i] != 0) begin
            n++; s += 64'(hist[i]); q += 64'(hist[i]) * 64'(hist[i]);
         end
         return n != 0 && (64'd5 * n * q < 64'd6 * s * s);
      endfunction

      function logic lock_ok(logic [15:0] supply);
         if (strict && (32'(held_conf) * 32'd5 < 32'd262144 || streak < 16'd5)) return 1'b0;
         if (mode == MODE_AUTO && span < 32'd1000) return 1'b0;
         return supply != '0;
      endfunction

      function void note(kind_type kind, logic [31:0] now, logic hit,
                         logic [15:0] conf, logic [15:0] supply);
         verdict_type v;
         outcome_type oc;
         logic lk, ls;
         lk = 1'b0; ls = 1'b0; oc = OUT_IGNORED;
         if (kind == KIND_START) begin
            running = mode != MODE_OFF;
            if (running) begin
               status = ST_NONE; streak = '0; last_t = '0; lock_t0 = '0; slot = 0;
               foreach (hist[i]) hist[i] = '0;
            end
         end else if (kind == KIND_STOP) begin
            running = 1'b0; status = ST_NONE;
         end else if (kind == KIND_NONE || !running) begin
         end else if (last_t != 0 && (now - last_t) < 32'(cooldown)) begin
            oc = OUT_COOLDOWN;
         end else begin
            oc = OUT_PROCESSED;
            frames++;
            if (hit) begin
               hits++;
               if (streak != 16'hFFFF) streak++;
               held_conf = conf; event_t = now;
               stable = history_stable();
               if (status == ST_NONE || status == ST_LOST) status = ST_DETECTED;
               else if (status == ST_DETECTED && streak >= 16'd3 && stable) begin
                  status = ST_LOCKED; lock_t0 = now; locks++;
               end
               if (status == ST_LOCKED) span = now - lock_t0;
            end else begin
               streak = '0;
               if (status == ST_DETECTED || status == ST_LOCKED) begin
                  status = ST_LOST; event_t = now;
               end else if (status == ST_LOST && (now - event_t) > 32'd1000) begin
                  status = ST_NONE; span = '0;
               end
            end
            hist[slot] = conf;
            slot = (slot + 1) % 5;
            last_t = now;
            if (mode != MODE_MONITOR) begin
               if (status == ST_LOCKED) begin
                  if (!lock_ok(supply)) status = ST_DETECTED;
                  else begin
                     lk = 1'b1;
                     if (span > 32'(lock_limit)) status = ST_DETECTED;
                  end
               end else if (status == ST_LOST) ls = 1'b1;
            end
         end
         v = '{oc, status, lk, ls, stable, streak, span, frames, hits, locks};
         pending.push_back(v);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
         errors++;
      endtask

      task check(logic [1:0] user, logic [151:0] data);
         verdict_type e;
         if (pending.size() == 0) begin
            report("unexpected beat", data[31:0], 0);
            return;
         end
         e = pending.pop_front();
         matched++;
         if (user != e.outcome) report("outcome", user, e.outcome);
         if (data[1:0] != e.status) report("track_status", data[1:0], e.status);
         if (data[2] != e.lock_ev) report("lock_event", data[2], e.lock_ev);
         if (data[3] != e.lost_ev) report("lost_event", data[3], e.lost_ev);
         if (data[4] != e.stable) report("stable", data[4], e.stable);
         if (data[20:5] != e.streak) report("hit_streak", data[20:5], e.streak);
         if (data[52:21] != e.lock_time) report("lock_span_ms", data[52:21], e.lock_time);
         if (data[84:53] != e.frames) report("frames_seen", data[84:53], e.frames);
         if (data[116:85] != e.hits) report("hits_seen", data[116:85], e.hits);
         if (data[148:117] != e.locks) report("locks_seen", data[148:117], e.locks);
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0, csr_valid = 0;
   logic [71:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic req_tready, rsp_tvalid, csr_ready;
   logic [151:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic [3:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   tracker_board_type board;
   int send_idle = 0, recv_idle = 0;
   int hold_off = 0;
   int quiet = 0;
   int sent = 0;
   logic [31:0] clock_ms = 0;

   detection_lock_tracker i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Result side: random stalls plus an optional long hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check(rsp_tuser, rsp_tdata);
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= !reset && ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 20000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The valid of the previous beat stays up until a gap or the next beat replaces it.
   task automatic send(kind_type kind, logic [31:0] now, logic hit,
                       logic [15:0] conf, logic [15:0] supply);
      csr_valid <= 1'b0;
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, supply, conf, hit, now};
      do @(posedge clock); while (!req_tready);
      board.note(kind, now, hit, conf, supply);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // The write valid is dropped by the beat that follows the last write.
   task automatic write_csr(logic [3:0] idx, logic [15:0] val);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
   endtask

   // A frame some milliseconds after the previous one.
   task automatic frame(int step, logic hit, logic [15:0] conf, logic [15:0] supply);
      clock_ms += 32'(step);
      send(KIND_FRAME, clock_ms, hit, conf, supply);
   endtask

   task automatic random_phase(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 3)
            send(KIND_START, $urandom, 1'($urandom), 16'($urandom), 16'($urandom));
         else if (r < 5)
            send(KIND_STOP, $urandom, 1'($urandom), 16'($urandom), 16'($urandom));
         else if (r < 6)
            send(KIND_NONE, $urandom, 1'($urandom), 16'($urandom), 16'($urandom));
         else if (r < 10)
            send(KIND_FRAME, $urandom, 1'($urandom), 16'($urandom), 16'($urandom));
         else frame(($urandom_range(3) == 0) ? $urandom_range(1500) : $urandom_range(400, 1300),
                    $urandom_range(5) != 0,
                    ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(52000, 65535)),
                    ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom));
      end
   endtask

   initial begin
      board = new();
      board.clear();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: default monitor mode, lock run, loss and timeout, extremes.
      send(KIND_FRAME, 32'd100, 1'b1, 16'hFFFF, 16'd5);
      send(KIND_START, 32'd0, 1'b0, 16'd0, 16'd0);
      send(KIND_FRAME, 32'd0, 1'b1, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < 6; i++) frame(600, 1'b1, 16'd60000, 16'd7);
      frame(100, 1'b1, 16'd60000, 16'd7);
      frame(600, 1'b0, 16'd0, 16'd7);
      frame(1500, 1'b0, 16'hFFFF, 16'd7);
      send(KIND_FRAME, 32'hFFFF_FFFF, 1'b1, 16'd1, 16'hFFFF);
      send(KIND_NONE, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF);
      send(KIND_STOP, 32'd0, 1'b0, 16'd0, 16'd0);
      drain();
      write_csr(CSR_RUN_MODE, 16'(MODE_AUTO));
      write_csr(CSR_COOLDOWN, 16'd0);
      write_csr(CSR_LOCK_LIMIT, 16'hFFFF);
      write_csr(CSR_STRICT, 16'd0);
      send(KIND_START, 32'd0, 1'b0, 16'd0, 16'd0);
      clock_ms = 5000;
      for (int i = 0; i < 8; i++) frame(400, 1'b1, 16'd60000, (i == 6) ? 16'd0 : 16'd3);
      frame(400, 1'b0, 16'd60000, 16'd3);
      drain();
      write_csr(CSR_RUN_MODE, 16'(MODE_OFF));
      send(KIND_START, 32'd0, 1'b0, 16'd0, 16'd0);
      frame(10, 1'b1, 16'd100, 16'd1);

      // Random phases over several register settings and idling profiles.
      for (int p = 0; p < 6; p++) begin
         drain();
         send_idle = (p < 2) ? 16 : (p < 4) ? 67 : 0;
         recv_idle = (p < 2) ? 67 : (p < 4) ? 16 : 0;
         write_csr(CSR_RUN_MODE, 16'(p == 5 ? MODE_MONITOR : (p % 2) ? MODE_ASSISTED : MODE_AUTO));
         write_csr(CSR_COOLDOWN, (p == 4) ? 16'hFFFF : 16'($urandom_range(0, 600)));
         write_csr(CSR_LOCK_LIMIT, (p == 3) ? 16'd0 : 16'($urandom_range(500, 6000)));
         write_csr(CSR_STRICT, 16'(p % 2));
         send(KIND_START, 32'd0, 1'b0, 16'd0, 16'd0);
         if (p == 2) hold_off = 400;
         random_phase(210);
      end

      drain();
      $display("Ran %0d beats in every run mode and strict setting, %0d results checked.",
               sent, board.matched);
      if (board.errors == 0 && board.pending.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
